// ----- hdl/aff2d_pkg.sv -----
// Shared types, constants and helpers for the 2D affine point transform.
// No dependencies; every file but aff2d_div refers to this package.
package aff2d_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH   = 8;

  localparam logic [1:0] MODE_POINT   = 2'd0;
  localparam logic [1:0] MODE_VECTOR  = 2'd1;
  localparam logic [1:0] MODE_INVERSE = 2'd2;

  localparam logic [2:0] REG_A  = 3'd0;
  localparam logic [2:0] REG_B  = 3'd1;
  localparam logic [2:0] REG_C  = 3'd2;
  localparam logic [2:0] REG_D  = 3'd3;
  localparam logic [2:0] REG_TX = 3'd4;
  localparam logic [2:0] REG_TY = 3'd5;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
  } cfg_t;

  // One queued item: finished forward result, or inverse numerators and offsets
  typedef struct packed {
    logic               inv;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic               fsat;
    logic signed [65:0] nx;
    logic signed [65:0] ny;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
  } qent_t;

  // Returns {clip, value} for a 67-bit signed input clamped to 32 bits
  function automatic logic [32:0] sat32(input logic signed [66:0] v);
    logic [32:0] r;
    if (v > 67'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -67'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

// ----- hdl/affine_2d_point_transform_unit.sv -----
// Point and vector items: the strobe follows registers s1, s2, s3, the queue and done_q;
// one per cycle unless busy or an inverse item holds the back end. Inverse items: the shared
// bit-serial divider pair holds the back end; the eight-entry queue keeps taking items.
// busy rises only when the queue and front pipeline hold eight items; results cannot stall.
// Reset clears all control state and sets the matrix to identity with no translation.
// Top level: APB register file, determinant pipeline, front, queue and back end.
module affine_2d_point_transform_unit #(
  parameter int unsigned FRAC_BITS = aff2d_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] in_x_i,
  input  logic signed [31:0] in_y_i,
  output logic               done_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic               singular_o,
  output logic               saturated_o
);

  aff2d_pkg::cfg_t  cfg_q;
  aff2d_pkg::qent_t push_data, head;
  logic push, pop, head_valid;
  logic [2:0] idx;
  logic wr_en;
  logic signed [63:0] ad_q, bc_q, det_q;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a  <= 32'sd1 <<< FRAC_BITS;
      cfg_q.b  <= '0;
      cfg_q.c  <= '0;
      cfg_q.d  <= 32'sd1 <<< FRAC_BITS;
      cfg_q.tx <= '0;
      cfg_q.ty <= '0;
    end else if (wr_en) begin
      unique case (idx)
        aff2d_pkg::REG_A:  cfg_q.a  <= pwdata;
        aff2d_pkg::REG_B:  cfg_q.b  <= pwdata;
        aff2d_pkg::REG_C:  cfg_q.c  <= pwdata;
        aff2d_pkg::REG_D:  cfg_q.d  <= pwdata;
        aff2d_pkg::REG_TX: cfg_q.tx <= pwdata;
        aff2d_pkg::REG_TY: cfg_q.ty <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      aff2d_pkg::REG_A:  prdata = cfg_q.a;
      aff2d_pkg::REG_B:  prdata = cfg_q.b;
      aff2d_pkg::REG_C:  prdata = cfg_q.c;
      aff2d_pkg::REG_D:  prdata = cfg_q.d;
      aff2d_pkg::REG_TX: prdata = cfg_q.tx;
      aff2d_pkg::REG_TY: prdata = cfg_q.ty;
      default:           prdata = '0;
    endcase
  end

  // Determinant wraps at 64 bits; registered as products in ad_q, bc_q, then in det_q
  always_ff @(posedge clk_i) begin
    ad_q  <= 64'(cfg_q.a) * 64'(cfg_q.d);
    bc_q  <= 64'(cfg_q.b) * 64'(cfg_q.c);
    det_q <= ad_q - bc_q;
  end

  aff2d_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .start, .busy, .mode_i, .in_x_i, .in_y_i,
    .pop_i(pop), .push_o(push), .push_data_o(push_data)
  );

  aff2d_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .pop_i(pop),
    .valid_o(head_valid), .head_o(head)
  );

  aff2d_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .head_valid_i(head_valid), .head_i(head), .det_i(det_q),
    .pop_o(pop), .done_o, .out_x_o, .out_y_o, .singular_o, .saturated_o
  );

endmodule

// ----- hdl/aff2d_front.sv -----
// Front end: accepts items, classifies the mode, forms products and sums,
// and finishes forward results. Depends on aff2d_pkg.
module aff2d_front #(
  parameter int unsigned FRAC_BITS = aff2d_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  aff2d_pkg::cfg_t      cfg_i,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           mode_i,
  input  logic signed [31:0]   in_x_i,
  input  logic signed [31:0]   in_y_i,
  input  logic                 pop_i,
  output logic                 push_o,
  output aff2d_pkg::qent_t     push_data_o
);

  localparam int unsigned CW = $clog2(aff2d_pkg::QUEUE_DEPTH + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic accept;

  logic s1_v_q, s1_inv_q, s1_vec_q;
  logic signed [32:0] s1_u_q, s1_w_q;
  logic s2_v_q, s2_inv_q, s2_vec_q;
  logic signed [32:0] s2_u_q, s2_w_q;
  logic signed [64:0] p0_q, p1_q, p2_q, p3_q;
  logic s3_v_q, s3_vec_q, s3_inv_q;
  logic signed [32:0] s3_u_q, s3_w_q;
  logic signed [65:0] s3_sx_q, s3_sy_q;

  logic inv_in, vec_in;
  logic signed [32:0] x_ext, y_ext, dx_in, dy_in;
  logic signed [31:0] m_lo, m_hi;
  logic signed [65:0] sh_x, sh_y;
  logic signed [31:0] t_x, t_y;
  logic [32:0] sat_x, sat_y;

  // Credits cover items in the pipeline and in the queue
  assign busy   = (cnt_q == CW'(aff2d_pkg::QUEUE_DEPTH));
  assign accept = start & ~busy;
  assign cnt_d  = cnt_q + CW'(accept) - CW'(pop_i);

  assign inv_in = (mode_i == aff2d_pkg::MODE_INVERSE);
  assign vec_in = (mode_i == aff2d_pkg::MODE_VECTOR);
  assign x_ext  = 33'(in_x_i);
  assign y_ext  = 33'(in_y_i);
  assign dx_in  = x_ext - 33'(cfg_i.tx);
  assign dy_in  = y_ext - 33'(cfg_i.ty);

  assign m_lo = s1_inv_q ? cfg_i.d : cfg_i.a;
  assign m_hi = s1_inv_q ? cfg_i.a : cfg_i.d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_inv_q <= inv_in;
    s1_vec_q <= vec_in;
    s1_u_q   <= inv_in ? dx_in : x_ext;
    s1_w_q   <= inv_in ? dy_in : y_ext;

    s2_inv_q <= s1_inv_q;
    s2_vec_q <= s1_vec_q;
    s2_u_q   <= s1_u_q;
    s2_w_q   <= s1_w_q;
    p0_q     <= 65'(m_lo) * 65'(s1_u_q);
    p1_q     <= 65'(cfg_i.c) * 65'(s1_w_q);
    p2_q     <= 65'(cfg_i.b) * 65'(s1_u_q);
    p3_q     <= 65'(m_hi) * 65'(s1_w_q);

    s3_inv_q <= s2_inv_q;
    s3_vec_q <= s2_vec_q;
    s3_u_q   <= s2_u_q;
    s3_w_q   <= s2_w_q;
    s3_sx_q  <= s2_inv_q ? 66'(p0_q) - 66'(p1_q) : 66'(p0_q) + 66'(p1_q);
    s3_sy_q  <= s2_inv_q ? 66'(p3_q) - 66'(p2_q) : 66'(p2_q) + 66'(p3_q);
  end

  // Floor Q.2F sum to Q.F, add translation unless vector mode, clamp to 32 bits
  assign sh_x  = s3_sx_q >>> FRAC_BITS;
  assign sh_y  = s3_sy_q >>> FRAC_BITS;
  assign t_x   = s3_vec_q ? 32'sd0 : cfg_i.tx;
  assign t_y   = s3_vec_q ? 32'sd0 : cfg_i.ty;
  assign sat_x = aff2d_pkg::sat32(67'(sh_x) + 67'(t_x));
  assign sat_y = aff2d_pkg::sat32(67'(sh_y) + 67'(t_y));

  assign push_o           = s3_v_q;
  assign push_data_o.inv  = s3_inv_q;
  assign push_data_o.fx   = sat_x[31:0];
  assign push_data_o.fy   = sat_y[31:0];
  assign push_data_o.fsat = sat_x[32] | sat_y[32];
  assign push_data_o.nx   = s3_sx_q;
  assign push_data_o.ny   = s3_sy_q;
  assign push_data_o.dx   = s3_u_q;
  assign push_data_o.dy   = s3_w_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(aff2d_pkg::QUEUE_DEPTH))
    else $error("credit count above queue depth");
  a_push_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> cnt_q != '0)
    else $error("push without a held credit");
  a_pop_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop without a held credit");

endmodule

// ----- hdl/aff2d_fifo.sv -----
// Short queue between front and back end, register based.
// Depends on aff2d_pkg for the entry type and depth.
module aff2d_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  aff2d_pkg::qent_t push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output aff2d_pkg::qent_t head_o
);

  localparam int unsigned DEPTH = aff2d_pkg::QUEUE_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);

  aff2d_pkg::qent_t mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [AW:0]   count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + AW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + AW'(1);
      count_q <= count_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && !pop_i && count_q == (AW+1)'(DEPTH)))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue underflow");

endmodule

// ----- hdl/aff2d_div.sv -----
// Bit-serial restoring divider: trunc(|num| * 2^F / dm), signed and clamped.
// One quotient bit per step; depends on no package items.
module aff2d_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic               step_i,
  input  logic signed [65:0] num_i,
  input  logic [63:0]        dm_i,
  input  logic               den_neg_i,
  output logic [31:0]        res_o,
  output logic               clip_o
);

  localparam int unsigned NW = 66 + FRAC_BITS;
  localparam int unsigned HW = NW - 32;
  localparam int unsigned KW = (HW > 64) ? HW : 64;

  logic [65:0]    mag;
  logic [NW-1:0]  nsh;
  logic [HW-1:0]  hi;
  logic           ovf;
  logic [63:0]    rem_q, dm_q;
  logic [31:0]    low_q, quo_q;
  logic           ovf_q, neg_q;
  logic [64:0]    r2, diff;
  logic           ge;
  logic [31:0]    lim;

  assign mag = num_i[65] ? 66'(-num_i) : 66'(num_i);
  assign nsh = NW'(mag) << FRAC_BITS;
  assign hi  = nsh[NW-1:32];
  // Quotient needs more than 32 bits when the upper part already reaches dm
  assign ovf = (KW'(hi) >= KW'(dm_i));

  assign r2   = {rem_q, low_q[31]};
  assign diff = r2 - {1'b0, dm_q};
  assign ge   = (r2 >= {1'b0, dm_q});

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= 64'(hi);
      low_q <= nsh[31:0];
      quo_q <= '0;
      dm_q  <= dm_i;
      ovf_q <= ovf;
      neg_q <= num_i[65] ^ den_neg_i;
    end else if (step_i) begin
      rem_q <= ge ? diff[63:0] : r2[63:0];
      low_q <= {low_q[30:0], 1'b0};
      quo_q <= {quo_q[30:0], ge};
    end
  end

  assign lim    = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign clip_o = ovf_q | (quo_q > lim);
  assign res_o  = clip_o ? lim : (neg_q ? (~quo_q + 32'd1) : quo_q);

endmodule

// ----- hdl/aff2d_back.sv -----
// Back end: drains the queue, emits forward results, runs inverse divisions
// and the singular fallback. Depends on aff2d_pkg and aff2d_div.
module aff2d_back #(
  parameter int unsigned FRAC_BITS = aff2d_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  aff2d_pkg::qent_t   head_i,
  input  logic signed [63:0] det_i,
  output logic               pop_o,
  output logic               done_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic               singular_o,
  output logic               saturated_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [31:0] ox_q, ox_d, oy_q, oy_d;
  logic        sing_q, sing_d, sat_q, sat_d;

  logic        det_zero, load, step;
  logic [63:0] dm;
  logic [32:0] fb_x, fb_y;
  logic [31:0] qx, qy;
  logic        cx, cy;

  assign det_zero = (det_i == 64'sd0);
  assign dm       = det_i[63] ? 64'(-det_i) : 64'(det_i);
  assign pop_o    = (state_q == ST_IDLE) && head_valid_i;
  assign load     = pop_o && head_i.inv && !det_zero;
  assign step     = (state_q == ST_DIV);
  assign fb_x     = aff2d_pkg::sat32(67'(head_i.dx));
  assign fb_y     = aff2d_pkg::sat32(67'(head_i.dy));

  aff2d_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i, .load_i(load), .step_i(step), .num_i(head_i.nx), .dm_i(dm),
    .den_neg_i(det_i[63]), .res_o(qx), .clip_o(cx)
  );
  aff2d_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i, .load_i(load), .step_i(step), .num_i(head_i.ny), .dm_i(dm),
    .den_neg_i(det_i[63]), .res_o(qy), .clip_o(cy)
  );

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    ox_d    = ox_q;
    oy_d    = oy_q;
    sing_d  = sing_q;
    sat_d   = sat_q;
    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          if (!head_i.inv) begin
            done_d = 1'b1;
            ox_d   = head_i.fx;
            oy_d   = head_i.fy;
            sing_d = 1'b0;
            sat_d  = head_i.fsat;
          end else if (det_zero) begin
            done_d = 1'b1;
            ox_d   = fb_x[31:0];
            oy_d   = fb_y[31:0];
            sing_d = 1'b1;
            sat_d  = fb_x[32] | fb_y[32];
          end else begin
            state_d = ST_DIV;
            cnt_d   = '0;
          end
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) state_d = ST_FIN;
      end
      ST_FIN: begin
        done_d  = 1'b1;
        ox_d    = qx;
        oy_d    = qy;
        sing_d  = 1'b0;
        sat_d   = cx | cy;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ox_q   <= ox_d;
    oy_q   <= oy_d;
    sing_q <= sing_d;
    sat_q  <= sat_d;
  end

  assign done_o      = done_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign singular_o  = sing_q;
  assign saturated_o = sat_q;

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> head_valid_i)
    else $error("pop from empty queue");
  a_div_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> !pop_o)
    else $error("queue drained during division");
  a_fin_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |=> done_o && !singular_o)
    else $error("division finished without a result");

endmodule
